>>> rtl/core/ertc_pkg.sv
// ----------------------------------------------------------------------------
// Epoch RTC converter package
// Shared types, constants and the month length table for the converter.
// ----------------------------------------------------------------------------
package ertc_pkg;

  localparam logic [33:0] SecPerDay  = 34'd86400;
  localparam logic [33:0] SecPerHour = 34'd3600;
  localparam logic [33:0] SecPerMin  = 34'd60;
  localparam logic [11:0] LastYear   = 12'd2099;
  localparam logic [11:0] BaseYear   = 12'd1900;

  // Controller states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_YEAR = 7'b0000010,
    S_MON  = 7'b0000100,
    S_DAY  = 7'b0001000,
    S_HOUR = 7'b0010000,
    S_MIN  = 7'b0100000,
    S_FIN  = 7'b1000000
  } ertc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic yr_step;
    logic mon_step;
    logic day_step;
    logic hr_step;
    logic min_step;
    logic capture;
  } ertc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_cmd1;
    logic yr_cont;
    logic mon_cont;
    logic day_cont;
    logic hr_cont;
    logic min_cont;
    logic oor;
    logic century;
  } ertc_sts_t;

  // One result item.
  typedef struct packed {
    logic [31:0] out_seconds;
    logic [6:0]  out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic        century_flag;
    logic        out_of_range;
  } ertc_res_t;

  // Seconds in a year.
  function automatic logic [33:0] year_secs(input logic leap);
    return leap ? 34'd31622400 : 34'd31536000;
  endfunction

  // Seconds in a month, zero based month index.
  function automatic logic [33:0] month_secs(input logic [3:0] m0, input logic leap);
    logic [33:0] d;
    case (m0)
      4'd1:    d = leap ? 34'd29 : 34'd28;
      4'd3:    d = 34'd30;
      4'd5:    d = 34'd30;
      4'd8:    d = 34'd30;
      4'd10:   d = 34'd30;
      default: d = 34'd31;
    endcase
    return 34'(d * SecPerDay);
  endfunction

endpackage

>>> rtl/core/ertc_ctrl.sv
// ----------------------------------------------------------------------------
// Epoch RTC converter controller
// Sequences the year, month, day, hour and minute loops of the datapath.
// ----------------------------------------------------------------------------
module ertc_ctrl import ertc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  input  ertc_sts_t sts_i,
  output logic      in_ready_o,
  output ertc_cmd_t cmd_o
);

  ertc_state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_YEAR;
        end
      end
      S_YEAR: begin
        cmd_o.yr_step = sts_i.yr_cont;
        if (!sts_i.yr_cont) begin
          state_d = sts_i.oor ? S_FIN : S_MON;
        end
      end
      S_MON: begin
        cmd_o.mon_step = sts_i.mon_cont;
        if (!sts_i.mon_cont) begin
          state_d = sts_i.is_cmd1 ? S_FIN : S_DAY;
        end
      end
      S_DAY: begin
        cmd_o.day_step = sts_i.day_cont;
        if (!sts_i.day_cont) state_d = S_HOUR;
      end
      S_HOUR: begin
        cmd_o.hr_step = sts_i.hr_cont;
        if (!sts_i.hr_cont) state_d = S_MIN;
      end
      S_MIN: begin
        cmd_o.min_step = sts_i.min_cont;
        if (!sts_i.min_cont) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/ertc_dp.sv
// ----------------------------------------------------------------------------
// Epoch RTC converter datapath
// Accumulator, year counter with leap tracking, and unit counters.
// ----------------------------------------------------------------------------
module ertc_dp import ertc_pkg::*; #(
  parameter int EPOCH_YEAR = 1970
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ertc_cmd_t   cmd_i,
  input  logic        in_cmd_i,
  input  logic [31:0] in_epoch_seconds_i,
  input  logic [6:0]  in_year_i,
  input  logic [3:0]  in_month_i,
  input  logic [4:0]  in_day_i,
  input  logic [4:0]  in_hour_i,
  input  logic [5:0]  in_minute_i,
  input  logic [5:0]  in_second_i,
  output ertc_sts_t   sts_o,
  output ertc_res_t   res_o
);

  localparam logic [11:0] EpochYear = 12'(EPOCH_YEAR);
  localparam logic [1:0]  Y4Init    = 2'(EPOCH_YEAR % 4);
  localparam logic [6:0]  Y100Init  = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0]  Y400Init  = 9'(EPOCH_YEAR % 400);

  logic        cmd1_q;
  logic [33:0] acc_q;
  logic [11:0] yr_q, full_q;
  logic [1:0]  y4_q;
  logic [6:0]  y100_q;
  logic [8:0]  y400_q;
  logic [3:0]  m0_q, mon_q;
  logic [4:0]  dcnt_q, hcnt_q;
  logic [5:0]  mcnt_q;
  logic        leap1_q;
  logic        century_q, century_d;

  logic        leap_cnt, leap_mon, full_big;
  logic [33:0] ysecs, msecs, time_sum;
  logic [3:0]  mon_c;
  logic [4:0]  day_c, day_out;
  logic [7:0]  yy;
  logic [5:0]  se;

  // Leap year from the running remainders, and the seconds of the current units.
  assign leap_cnt = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));
  assign leap_mon = cmd1_q ? leap1_q : leap_cnt;
  assign ysecs    = year_secs(leap_cnt);
  assign msecs    = month_secs(m0_q, leap_mon);
  assign full_big = (full_q > LastYear);

  // Clamped input fields and the time of day sum for a date request.
  assign mon_c    = (in_month_i == 4'd0) ? 4'd1 :
                    (in_month_i > 4'd12) ? 4'd12 : in_month_i;
  assign day_c    = (in_day_i == 5'd0) ? 5'd1 : in_day_i;
  assign time_sum = 34'(in_second_i)
                  + 34'(34'(in_minute_i) * SecPerMin)
                  + 34'(34'(in_hour_i) * SecPerHour)
                  + 34'(34'(day_c - 5'd1) * SecPerDay);

  // Status for the controller.
  always_comb begin
    sts_o.is_cmd1  = cmd1_q;
    sts_o.yr_cont  = cmd1_q ? ((yr_q < full_q) && !full_big) : (acc_q >= ysecs);
    sts_o.mon_cont = cmd1_q ? ((m0_q + 4'd1) < mon_q) : ((m0_q < 4'd11) && (acc_q >= msecs));
    sts_o.day_cont = (acc_q >= SecPerDay);
    sts_o.hr_cont  = (acc_q >= SecPerHour);
    sts_o.min_cont = (acc_q >= SecPerMin);
    sts_o.oor      = cmd1_q ? full_big : (yr_q > LastYear);
    sts_o.century  = century_q;
  end

  // Result assembly.
  always_comb begin
    yy        = 8'(yr_q - BaseYear);
    century_d = century_q;
    res_o     = '0;
    day_out   = dcnt_q + 5'd1;
    se        = acc_q[5:0];
    if (yy > 8'd99) yy = yy - 8'd100;
    if ((day_out >= 5'd28) && (day_out <= 5'd30) && (hcnt_q == 5'd23) &&
        (mcnt_q == 6'd59) && (se >= 6'd58)) se = 6'd57;
    if (cmd1_q) begin
      res_o.out_of_range = full_big || (acc_q[33:32] != 2'd0);
      if (!res_o.out_of_range) res_o.out_seconds = acc_q[31:0];
    end else if (yr_q > LastYear) begin
      res_o.out_of_range = 1'b1;
    end else begin
      if (8'(yr_q - BaseYear) > 8'd99) century_d = 1'b1;
      res_o.out_year   = yy[6:0];
      res_o.out_month  = m0_q + 4'd1;
      res_o.out_day    = day_out;
      res_o.out_hour   = hcnt_q;
      res_o.out_minute = mcnt_q;
      res_o.out_second = se;
    end
    res_o.century_flag = century_d;
  end

  // Century bit, cleared only by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      century_q <= 1'b0;
    end else if (cmd_i.capture) begin
      century_q <= century_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd1_q  <= in_cmd_i;
      acc_q   <= in_cmd_i ? time_sum : 34'(in_epoch_seconds_i);
      yr_q    <= EpochYear;
      y4_q    <= Y4Init;
      y100_q  <= Y100Init;
      y400_q  <= Y400Init;
      full_q  <= 12'(in_year_i) + BaseYear + (century_q ? 12'd100 : 12'd0);
      leap1_q <= (in_year_i[1:0] == 2'd0) && ((in_year_i != 7'd0) || century_q);
      mon_q   <= mon_c;
      m0_q    <= 4'd0;
      dcnt_q  <= 5'd0;
      hcnt_q  <= 5'd0;
      mcnt_q  <= 6'd0;
    end
    if (cmd_i.yr_step) begin
      acc_q  <= cmd1_q ? (acc_q + ysecs) : (acc_q - ysecs);
      yr_q   <= yr_q + 12'd1;
      y4_q   <= y4_q + 2'd1;
      y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
      y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
    end
    if (cmd_i.mon_step) begin
      acc_q <= cmd1_q ? (acc_q + msecs) : (acc_q - msecs);
      m0_q  <= m0_q + 4'd1;
    end
    if (cmd_i.day_step) begin
      acc_q  <= acc_q - SecPerDay;
      dcnt_q <= dcnt_q + 5'd1;
    end
    if (cmd_i.hr_step) begin
      acc_q  <= acc_q - SecPerHour;
      hcnt_q <= hcnt_q + 5'd1;
    end
    if (cmd_i.min_step) begin
      acc_q  <= acc_q - SecPerMin;
      mcnt_q <= mcnt_q + 6'd1;
    end
  end

endmodule

>>> rtl/core/epoch_rtc_date_converter_unit.sv
// ----------------------------------------------------------------------------
// Epoch RTC date converter
// Converts seconds since the epoch year to a clock date and back.
// ----------------------------------------------------------------------------
// Usage: a request arrives on the s_axis channel; tuser selects the
// direction (0 seconds to date, 1 date to seconds). Each request gives one
// result on the m_axis channel, with the century bit and an out-of-range
// flag in tuser.
// Sequencing: after the accept, the shared accumulator counts off the year
// steps, month steps, days, hours and minutes in turn, each loop ending when
// it has no more steps to take, and the final state captures the result.
// Date to seconds counts off only the years since the epoch and the months;
// in either direction an out-of-range year goes straight to the final state.
// One request is in the datapath at a time; s_axis_tready_o is high while
// the controller is idle, also while a result waits in the output register.
// Reset clears the controller, the output valid flag and the century bit.
// When the receiver stalls, the result holds in the output register and the
// next request stops in its final state until the register frees up.
// ----------------------------------------------------------------------------
module epoch_rtc_date_converter_unit import ertc_pkg::*; #(
  parameter int EPOCH_YEAR = 1970
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // epoch_seconds[31:0], in_year[38:32], in_month[42:39], in_day[47:43],
  // in_hour[52:48], in_minute[58:53], in_second[64:59], zero fill
  input  logic [71:0] s_axis_tdata_i,
  // cmd[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_seconds[31:0], out_year[38:32], out_month[42:39], out_day[47:43],
  // out_hour[52:48], out_minute[58:53], out_second[64:59], zero fill
  output logic [71:0] m_axis_tdata_o,
  // century_flag[0], out_of_range[1]
  output logic [1:0]  m_axis_tuser_o
);

  ertc_cmd_t cmd;
  ertc_sts_t sts;
  ertc_res_t res, res_q;
  logic      out_valid_q, out_free;

  assign out_free = !out_valid_q || m_axis_tready_i;

  ertc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  ertc_dp #(.EPOCH_YEAR(EPOCH_YEAR)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .in_cmd_i           (s_axis_tuser_i),
    .in_epoch_seconds_i (s_axis_tdata_i[31:0]),
    .in_year_i          (s_axis_tdata_i[38:32]),
    .in_month_i         (s_axis_tdata_i[42:39]),
    .in_day_i           (s_axis_tdata_i[47:43]),
    .in_hour_i          (s_axis_tdata_i[52:48]),
    .in_minute_i        (s_axis_tdata_i[58:53]),
    .in_second_i        (s_axis_tdata_i[64:59]),
    .sts_o              (sts),
    .res_o              (res)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.capture) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd.capture) res_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, res_q.out_second, res_q.out_minute, res_q.out_hour,
                            res_q.out_day, res_q.out_month, res_q.out_year,
                            res_q.out_seconds};
  assign m_axis_tuser_o  = {res_q.out_of_range, res_q.century_flag};

`ifndef NO_ASSERTIONS
  // The century bit only ever sets.
  a_century_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(sts.century)) else $error("century bit cleared");

  // An out-of-range result carries no seconds and no date.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (m_axis_tdata_o == 72'd0))
    else $error("out-of-range result has nonzero fields");

  // A result is captured only when the output register can take it.
  a_capture_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> out_free) else $error("result overwritten");
`endif

endmodule

>>> dv/epoch_rtc_date_converter_unit_test.sv
// ----------------------------------------------------------------------------
// Epoch RTC date converter testbench
// Drives seconds-to-date and date-to-seconds requests under random stalls on
// both channels and checks every result against an independent predictor.
// ----------------------------------------------------------------------------
module epoch_rtc_date_converter_unit_test;
  import ertc_pkg::*;

  localparam int unsigned EpochYear = 1970;
  localparam int unsigned MaxSecs   = 32'd4102444799;
  localparam logic        CmdToDate = 1'b0;
  localparam logic        CmdToSecs = 1'b1;

  // Converter date conversion model with its own century bit.
  class date_scoreboard;
    bit             century_bit;
    ertc_res_t      pending_q[$];
    int unsigned    mismatches;
    int unsigned    checked;

    function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function longint unsigned secs_of_year(int unsigned y);
      return (leap_year(y) ? 366 : 365) * 64'd86400;
    endfunction

    function longint unsigned secs_of_month(int unsigned m0, int unsigned y);
      int unsigned d;
      case (m0)
        1: d = leap_year(y) ? 29 : 28;
        3, 5, 8, 10: d = 30;
        default: d = 31;
      endcase
      return d * 64'd86400;
    endfunction

    // Work out the result of one accepted request and queue it.
    function void note_request(logic cmd, logic [71:0] data);
      ertc_res_t r;
      longint unsigned rem, s;
      int unsigned y, m0, day, hr, mi, se, full, mon;
      r = '0;
      if (cmd == CmdToDate) begin
        rem = 64'(data[31:0]);
        y = EpochYear;
        while (rem >= secs_of_year(y)) begin
          rem -= secs_of_year(y);
          y++;
        end
        if (y > 2099) begin
          r.out_of_range = 1'b1;
        end else begin
          m0 = 0;
          while (m0 < 11 && rem >= secs_of_month(m0, y)) begin
            rem -= secs_of_month(m0, y);
            m0++;
          end
          day = 32'(rem / 86400);
          rem -= day * 86400;
          day++;
          hr = 32'(rem / 3600);
          rem -= hr * 3600;
          mi = 32'(rem / 60);
          se = 32'(rem - mi * 60);
          y -= 1900;
          if (y > 99) begin
            y -= 100;
            century_bit = 1'b1;
          end
          // Seconds near the end of days 28 to 30 are held at 57.
          if (day >= 28 && day <= 30 && hr == 23 && mi == 59 && se >= 58) se = 57;
          r.out_year   = 7'(y);
          r.out_month  = 4'(m0 + 1);
          r.out_day    = 5'(day);
          r.out_hour   = 5'(hr);
          r.out_minute = 6'(mi);
          r.out_second = 6'(se);
        end
      end else begin
        full = 32'(data[38:32]) + 1900 + (century_bit ? 100 : 0);
        mon = 32'(data[42:39]);
        day = 32'(data[47:43]);
        if (full > 2099) begin
          r.out_of_range = 1'b1;
        end else begin
          if (mon == 0) mon = 1;
          if (mon > 12) mon = 12;
          if (day == 0) day = 1;
          s = 64'(data[64:59]) + 64'(data[58:53]) * 64'd60 + 64'(data[52:48]) * 64'd3600
              + 64'(day - 1) * 64'd86400;
          for (int i = 0; i + 1 < mon; i++) s += secs_of_month(i, full);
          for (int unsigned i = EpochYear; i < full; i++) s += secs_of_year(i);
          if (s > 64'hFFFF_FFFF) r.out_of_range = 1'b1;
          else r.out_seconds = s[31:0];
        end
      end
      r.century_flag = century_bit;
      pending_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [71:0] data, logic [1:0] user);
      ertc_res_t e;
      if (pending_q.size() == 0) begin
        $error("Result arrived with no request outstanding");
        mismatches++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (data[31:0] !== e.out_seconds) begin
        $error("out_seconds: expected %0d, actual %0d", e.out_seconds, data[31:0]);
        mismatches++;
      end
      if (data[38:32] !== e.out_year) begin
        $error("out_year: expected %0d, actual %0d", e.out_year, data[38:32]);
        mismatches++;
      end
      if (data[42:39] !== e.out_month) begin
        $error("out_month: expected %0d, actual %0d", e.out_month, data[42:39]);
        mismatches++;
      end
      if (data[47:43] !== e.out_day) begin
        $error("out_day: expected %0d, actual %0d", e.out_day, data[47:43]);
        mismatches++;
      end
      if (data[52:48] !== e.out_hour) begin
        $error("out_hour: expected %0d, actual %0d", e.out_hour, data[52:48]);
        mismatches++;
      end
      if (data[58:53] !== e.out_minute) begin
        $error("out_minute: expected %0d, actual %0d", e.out_minute, data[58:53]);
        mismatches++;
      end
      if (data[64:59] !== e.out_second) begin
        $error("out_second: expected %0d, actual %0d", e.out_second, data[64:59]);
        mismatches++;
      end
      if (data[71:65] !== 7'd0) begin
        $error("zero_fill: expected 0, actual %0d", data[71:65]);
        mismatches++;
      end
      if (user[0] !== e.century_flag) begin
        $error("century_flag: expected %0d, actual %0d", e.century_flag, user[0]);
        mismatches++;
      end
      if (user[1] !== e.out_of_range) begin
        $error("out_of_range: expected %0d, actual %0d", e.out_of_range, user[1]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  date_scoreboard date_sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    cycle_count;
  int unsigned    to_date_count;
  int unsigned    to_secs_count;

  epoch_rtc_date_converter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on the total cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls and result checking.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      date_sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one request and wait for its acceptance. The valid line drops only
  // when the sender idles or drains, so back-to-back requests keep it high.
  task automatic send_request(logic cmd, logic [71:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= data;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    date_sb.note_request(cmd, data);
    if (cmd == CmdToDate) to_date_count++;
    else to_secs_count++;
  endtask

  task automatic send_to_date(logic [31:0] secs);
    send_request(CmdToDate, {40'd0, secs});
  endtask

  task automatic send_to_secs(int unsigned yr, int unsigned mo, int unsigned dy,
                              int unsigned hr, int unsigned mi, int unsigned se);
    send_request(CmdToSecs, {7'd0, 6'(se), 6'(mi), 5'(hr), 5'(dy), 4'(mo), 7'(yr),
                             32'($urandom)});
  endtask

  // Random request, mostly well-formed values with some raw bit noise.
  task automatic send_random;
    int unsigned sel;
    logic [31:0] secs;
    sel = $urandom_range(99);
    if (sel < 40) begin
      secs = (sel < 30) ? $urandom_range(MaxSecs) : $urandom;
      // Bias some requests toward the last seconds of a day.
      if (sel < 10) secs = secs - (secs % 86400) + 86398 + $urandom_range(1);
      send_to_date(secs);
    end else if (sel < 85) begin
      send_to_secs($urandom_range(99), $urandom_range(12, 1), $urandom_range(31, 1),
                   $urandom_range(23), $urandom_range(59), $urandom_range(59));
    end else begin
      send_to_secs($urandom_range(127), $urandom_range(15), $urandom_range(31),
                   $urandom_range(31), $urandom_range(63), $urandom_range(63));
    end
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (date_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    date_sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    m_axis_tready_i = 1'b0;
    cycle_count = 0;
    send_idle_pct = 19;
    recv_idle_pct = 77;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: century bit still clear, date to seconds first.
    send_to_secs(0, 1, 1, 0, 0, 0);
    send_to_secs(70, 1, 1, 0, 0, 0);
    send_to_secs(99, 12, 31, 23, 59, 59);
    send_to_secs(127, 15, 31, 31, 63, 63);
    send_to_secs(75, 0, 0, 0, 0, 0);
    send_to_secs(72, 2, 29, 12, 30, 30);
    send_to_date(32'd0);
    send_to_date(32'd951782398);  // 2000-02-28 23:59:58, sets the century bit
    send_to_date(32'd946684799);
    send_to_secs(0, 1, 1, 0, 0, 0);
    send_to_secs(99, 12, 31, 23, 59, 59);
    send_to_secs(100, 13, 31, 23, 59, 59);
    send_to_secs(6, 2, 28, 6, 28, 16);
    send_to_date(32'(MaxSecs));
    send_to_date(32'(MaxSecs + 1));
    send_to_date(32'hFFFF_FFFF);
    send_to_date(32'd1209599);    // 1970-01-14 last second
    send_to_date(32'd2505599);    // 1970-01-29 23:59:59
    send_to_date(32'd5097599);    // end of the 1970-02-28 hot minute
    send_to_date(32'd2591999);    // day 30 hot second
    send_to_date(32'd2678399);    // day 31 left alone
    // Hold off until every directed result has come back.
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 19 : 0;
      for (int n = 0; n < 460; n++) send_random();
    end

    drain();
    repeat (300) @(posedge clk_i);
    $display("Covered %0d seconds-to-date and %0d date-to-seconds requests, %0d checked.",
             to_date_count, to_secs_count, date_sb.checked);
    if (date_sb.mismatches == 0 && date_sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
